// ===== hw/rtl/afsg_pkg.sv =====
// Package for the adaptive frame skip governor.
// Holds shared types and constants; no dependencies.
`default_nettype none

package afsg_pkg;

   localparam int unsigned DIV_WIDTH     = 32;
   localparam int unsigned DIV_CNT_WIDTH = $clog2(DIV_WIDTH);
   localparam int unsigned TARGET_WIDTH  = 31;
   localparam int unsigned LEVEL_WIDTH   = 6;
   localparam int unsigned PATTERN_BITS  = 5;
   localparam int unsigned PROD_WIDTH    = DIV_WIDTH + 7;

   localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = 31'd1000000;
   localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_MIN   = -6'sd25;
   localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_FAST  = -6'sd1;
   localparam logic signed [LEVEL_WIDTH-1:0] LEVEL_RESET = 6'sd0;
   localparam logic [DIV_WIDTH-1:0] AUTO_PERIOD = 32'd12;
   localparam logic [DIV_WIDTH-1:0] SKIP_START  = 32'd4;
   localparam logic [PROD_WIDTH-1:0] PCT_SCALE  = 39'd100;

   // register indexes
   localparam logic REG_TARGET  = 1'b0;
   localparam logic REG_INITIAL = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/adaptive_frame_skip_governor.sv =====
// Adaptive frame skip governor: top level with sequencer and output register.
// Depends on afsg_pkg and afsg_div.
//
// One request word per frame end; one response word (skip flag and level) per request.
// A word needs a division only for a positive level past the fourth frame (frame count
// modulo level+1), or when the automatic mode re-evaluates the average (time sum over
// frame count); otherwise it is answered without one. Both divisions run on one shared
// 32-bit restoring divider at one quotient bit per cycle; a stalled response register adds
// its stall to the word in work. req_stall is high while a word is in work; a finished
// response may wait in the output register while the next request is taken. Writing
// initial_skip loads the level at once; writes are meant for idle periods only.
`default_nettype none

module adaptive_frame_skip_governor (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_wr_en,
   input  wire logic                                     csr_index,
   input  wire logic [afsg_pkg::TARGET_WIDTH-1:0]        csr_wdata,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic                                     req_timer_valid,
   input  wire logic [afsg_pkg::DIV_WIDTH-1:0]           req_elapsed_ticks,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic                                          rsp_skip_frame,
   output logic signed [afsg_pkg::LEVEL_WIDTH-1:0]       rsp_skip_level
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LAUNCH_AVG,
      S_WAIT_AVG,
      S_MUL,
      S_CMP,
      S_SKIP,
      S_WAIT_MOD,
      S_FINISH
   } state_type;

   state_type                                   state_ff;
   logic [afsg_pkg::TARGET_WIDTH-1:0]           target_ff;
   logic signed [afsg_pkg::LEVEL_WIDTH-1:0]     level_ff;
   logic [afsg_pkg::DIV_WIDTH-1:0]              fc_ff, ts_ff, fs_ff, avg_ff;
   logic [afsg_pkg::PROD_WIDTH-1:0]             avg100_ff, fast_ff, slow_ff;
   logic                                        skip_ff;
   logic                                        rsp_valid_ff;
   logic                                        rsp_skip_ff;
   logic signed [afsg_pkg::LEVEL_WIDTH-1:0]     rsp_level_ff;

   logic [afsg_pkg::DIV_WIDTH-1:0]              fc_in, ts_in, fs_in;
   logic                                        adjust_in;
   logic                                        div_start;
   logic                                        mod_needed;
   logic [afsg_pkg::DIV_WIDTH-1:0]              div_dividend, div_divisor;
   logic [afsg_pkg::DIV_WIDTH-1:0]              div_quo, div_rem;
   afsg_pkg::div_status_type                    div_status;
   logic [afsg_pkg::PATTERN_BITS-1:0]           ruler, ruler_rev;
   logic [afsg_pkg::PATTERN_BITS:0]             level_mag;
   logic                                        neg_skip;
   logic [afsg_pkg::PROD_WIDTH-1:0]             avg_x, tgt_x;
   logic                                        out_free;

   // accept-time update of the counters
   always_comb begin
      fc_in = fc_ff + 1'b1;
      ts_in = ts_ff;
      fs_in = fs_ff;
      if (req_timer_valid) begin
         ts_in = ts_ff + req_elapsed_ticks;
         fs_in = fs_ff + 1'b1;
      end
      adjust_in = req_timer_valid && (level_ff < 0) && (fs_in > afsg_pkg::AUTO_PERIOD);
   end

   // ruler pattern: lowest changing bits of the counter, bit-reversed
   always_comb begin
      ruler = fc_ff[afsg_pkg::PATTERN_BITS-1:0] ^ fc_in[afsg_pkg::PATTERN_BITS-1:0];
      for (int i = 0; i < int'(afsg_pkg::PATTERN_BITS); i++) begin
         ruler_rev[afsg_pkg::PATTERN_BITS-1-i] = ruler[i];
      end
      level_mag = -level_ff;
      neg_skip  = {1'b0, ruler_rev} < level_mag;
   end

   assign mod_needed = (level_ff > 0) && (fc_ff > afsg_pkg::SKIP_START);
   assign div_start  = (state_ff == S_LAUNCH_AVG) || ((state_ff == S_SKIP) && mod_needed);

   always_comb begin
      if (state_ff == S_LAUNCH_AVG) begin
         div_dividend = ts_ff;
         div_divisor  = fs_ff;
      end else begin
         div_dividend = fc_ff;
         div_divisor  = afsg_pkg::DIV_WIDTH'(level_ff) + 1'b1;
      end
   end

   assign avg_x    = afsg_pkg::PROD_WIDTH'(avg_ff);
   assign tgt_x    = afsg_pkg::PROD_WIDTH'(target_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   afsg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= afsg_pkg::TARGET_RESET;
         level_ff     <= afsg_pkg::LEVEL_RESET;
         fc_ff        <= '0;
         ts_ff        <= '0;
         fs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a word handed on in the finishing state is replaced there, not cleared
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               afsg_pkg::REG_TARGET:  target_ff <= csr_wdata;
               afsg_pkg::REG_INITIAL: level_ff  <= csr_wdata[afsg_pkg::LEVEL_WIDTH-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  fc_ff    <= fc_in;
                  ts_ff    <= ts_in;
                  fs_ff    <= fs_in;
                  state_ff <= adjust_in ? S_LAUNCH_AVG : S_SKIP;
               end
            end
            S_LAUNCH_AVG: state_ff <= S_WAIT_AVG;
            S_WAIT_AVG: begin
               if (div_status.done) begin
                  avg_ff   <= div_quo;
                  ts_ff    <= '0;
                  fs_ff    <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               avg100_ff <= (avg_x << 6) + (avg_x << 5) + (avg_x << 2);
               fast_ff   <= (tgt_x << 6) + (tgt_x << 5) - tgt_x;
               slow_ff   <= (tgt_x << 6) + (tgt_x << 5) + (tgt_x << 3) + tgt_x;
               state_ff  <= S_CMP;
            end
            S_CMP: begin
               // avg < floor(95t/100) <=> 100*(avg+1) <= 95t; avg > floor(105t/100) <=> 105t < 100*avg
               if ((avg100_ff + afsg_pkg::PCT_SCALE <= fast_ff) &&
                   (level_ff < afsg_pkg::LEVEL_FAST)) begin
                  level_ff <= level_ff + 6'sd1;
               end else if ((slow_ff < avg100_ff) && (level_ff > afsg_pkg::LEVEL_MIN)) begin
                  level_ff <= level_ff - 6'sd1;
               end
               state_ff <= S_SKIP;
            end
            S_SKIP: begin
               if (mod_needed) begin
                  state_ff <= S_WAIT_MOD;
               end else begin
                  skip_ff  <= (level_ff < 0) && (fc_ff > afsg_pkg::SKIP_START) && neg_skip;
                  state_ff <= S_FINISH;
               end
            end
            S_WAIT_MOD: begin
               if (div_status.done) begin
                  skip_ff  <= (div_rem != '0);
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_skip_ff  <= skip_ff;
                  rsp_level_ff <= level_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_skip_frame = rsp_skip_ff;
   assign rsp_skip_level = rsp_level_ff;

   // divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // a division result only turns up while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_WAIT_AVG || state_ff == S_WAIT_MOD))
      else $error("divider result with no waiting state");

   // the running sum is cleared once the average is taken
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT_AVG && div_status.done) |=> (ts_ff == '0 && fs_ff == '0))
      else $error("running sum not cleared after evaluation");

   // the governor never steps an in-range level below the slowest setting
   a_level_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP && level_ff >= afsg_pkg::LEVEL_MIN) |=>
         (level_ff >= afsg_pkg::LEVEL_MIN))
      else $error("level stepped below floor");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(state_ff == S_FINISH && out_free))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/afsg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on afsg_pkg.
`default_nettype none

module afsg_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [afsg_pkg::DIV_WIDTH-1:0]  dividend,
   input  wire logic [afsg_pkg::DIV_WIDTH-1:0]  divisor,
   output logic [afsg_pkg::DIV_WIDTH-1:0]       quotient,
   output logic [afsg_pkg::DIV_WIDTH-1:0]       remainder,
   output afsg_pkg::div_status_type             status
);

   logic [afsg_pkg::DIV_WIDTH-1:0]     rem_ff, rem_in;
   logic [afsg_pkg::DIV_WIDTH-1:0]     quo_ff, quo_in;
   logic [afsg_pkg::DIV_WIDTH-1:0]     dsr_ff;
   logic [afsg_pkg::DIV_CNT_WIDTH-1:0] cnt_ff;
   logic                               busy_ff, done_ff;
   logic [afsg_pkg::DIV_WIDTH:0]       rem_sh, rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[afsg_pkg::DIV_WIDTH-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      if (!rem_sub[afsg_pkg::DIV_WIDTH]) begin
         rem_in = rem_sub[afsg_pkg::DIV_WIDTH-1:0];
         quo_in = {quo_ff[afsg_pkg::DIV_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[afsg_pkg::DIV_WIDTH-1:0];
         quo_in = {quo_ff[afsg_pkg::DIV_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
            cnt_ff  <= '1;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire
